// File: rtl/core/rbb_pkg.sv
package rbb_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W     = 12;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int COL_OUT_W = 11;
  localparam int ROW_OUT_W = 11;
  localparam int SUM_W     = 11;
  localparam int PROD_W    = 28;

  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_BANKS   = 4;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // floor(sum/5) and floor(sum/3) by reciprocal, exact for sums of up to five bytes
  localparam int DIV5_MUL = 13108;
  localparam int DIV3_MUL = 21846;

  typedef struct packed {
    logic has_out;
    logic last_row;
    logic col_end;
  } job_flags_t;

  localparam int FLAGS_W = $bits(job_flags_t);

  function automatic logic [CH_W-1:0] floor_mean(logic [SUM_W-1:0] sum, logic [2:0] cnt);
    logic [PROD_W-1:0] p;
    logic [CH_W-1:0]   q;
    p = '0;
    case (cnt)
      3'd5: begin
        p = PROD_W'(sum) * PROD_W'(DIV5_MUL);
        q = p[23:16];
      end
      3'd3: begin
        p = PROD_W'(sum) * PROD_W'(DIV3_MUL);
        q = p[23:16];
      end
      default: begin
        q = sum[9:2];
      end
    endcase
    return q;
  endfunction

  // Horizontal mean over window taps start..4, tap 4 being the newest pixel
  function automatic logic [PIX_W-1:0] hmean(logic [4:0][PIX_W-1:0] v, logic [1:0] start);
    logic [SUM_W-1:0] sum;
    logic [2:0]       cnt;
    logic [PIX_W-1:0] res;
    res = '0;
    cnt = 3'd5 - 3'(start);
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int i = 0; i < 5; i++) begin
        if (i >= int'(start)) begin
          sum = sum + SUM_W'(v[i][PIX_W-1-CH_W*ch -: CH_W]);
        end
      end
      res[PIX_W-1-CH_W*ch -: CH_W] = floor_mean(sum, cnt);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/rbb_if.sv
interface rbb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rbb_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] out_column;
  logic [10:0] out_row;
  logic        last_of_run;
  logic        frame_done;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output out_column, output out_row, output last_of_run, output frame_done,
                 input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input out_column, input out_row, input last_of_run, input frame_done,
               output ready);
endinterface

// File: rtl/core/rbb_front.sv
module rbb_front #(
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  rbb_pix_if.sink                          pix,
  input  logic                             cfg_we,
  input  logic [$clog2(MAX_WIDTH)-1:0]     w_last,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    h_last,
  input  logic                             queue_full,
  output logic                             push,
  output logic [2:0][rbb_pkg::PIX_W-1:0]   push_hv,
  output rbb_pkg::job_flags_t              push_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]     push_x0,
  output logic [$clog2(MAX_HEIGHT)-1:0]    push_r
);
  import rbb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [XW-1:0]     col;
  logic [YW-1:0]     row;
  logic [PIX_W-1:0]  win [4];
  logic              acc;
  logic [PIX_W-1:0]  cur;
  logic [4:0][PIX_W-1:0] vw;
  logic [1:0]        off;
  logic [1:0]        s1;

  assign pix.ready = !queue_full;
  assign acc = pix.valid && pix.ready;
  assign cur = {pix.red_in, pix.green_in, pix.blue_in};
  assign vw  = {cur, win[3], win[2], win[1], win[0]};

  // near the left edge the window reaches back into the previous row: trim it
  always_comb begin
    if (col == XW'(2)) off = 2'd2;
    else if (col == XW'(3)) off = 2'd1;
    else off = 2'd0;
    s1 = (off > 2'd1) ? off : 2'd1;
  end

  assign push_hv[0] = hmean(vw, off);
  assign push_hv[1] = hmean(vw, s1);
  assign push_hv[2] = hmean(vw, 2'd2);

  assign push                = acc && (col >= XW'(2));
  assign push_x0             = col - XW'(2);
  assign push_r              = row;
  assign push_flags.has_out  = row >= YW'(2);
  assign push_flags.last_row = row == h_last;
  assign push_flags.col_end  = col == w_last;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= cur;
    end
  end

endmodule

// File: rtl/core/rbb_fifo.sv
module rbb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = rbb_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full       = count == (AW+1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/core/rbb_back.sv
module rbb_back #(
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  logic [2:0][rbb_pkg::PIX_W-1:0]   head_hv,
  input  rbb_pkg::job_flags_t              head_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]     head_x0,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    head_r,
  output logic                             pop,
  rbb_res_if.source                        res
);
  import rbb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  // issue stage: one (column, row) step per cycle while the read stage can take it
  logic [1:0]       xi;
  logic [1:0]       yi;
  logic [1:0]       nx_last;
  logic [1:0]       ny_last;
  logic             x_step_last;
  logic             item_last;
  logic             a_adv;
  logic [XW-1:0]    cur_x;
  logic [YW-1:0]    cur_y;
  logic [PIX_W-1:0] hv_sel;
  logic [2:0]       span;

  // read stage
  logic             bv;
  logic [PIX_W-1:0] b_hv;
  logic [XW-1:0]    b_x;
  logic [YW-1:0]    b_y;
  logic [2:0]       b_span;
  logic [1:0]       b_rsel;
  logic             b_out;
  logic             b_last;
  logic             b_done;
  logic             b_move;
  logic             b_free;
  logic [PIX_W-1:0] rd [NUM_BANKS];

  logic             out_free;
  logic             o_load;
  logic [PIX_W-1:0] vmean;

  assign nx_last     = head_flags.col_end ? 2'd2 : 2'd0;
  assign ny_last     = (head_flags.has_out && head_flags.last_row) ? 2'd2 : 2'd0;
  assign x_step_last = yi == ny_last;
  assign item_last   = x_step_last && (xi == nx_last);
  assign cur_x       = head_x0 + XW'(xi);
  assign cur_y       = head_r - YW'(2) + YW'(yi);
  assign hv_sel      = head_hv[xi];

  // rows taken from the banks above the current row, counted from the current row
  always_comb begin
    case (yi)
      2'd0:    span = (head_r >= YW'(4)) ? 3'd4 : 3'(head_r);
      2'd1:    span = (head_r >= YW'(3)) ? 3'd3 : 3'(head_r);
      default: span = 3'd2;
    endcase
  end

  assign out_free = !res.valid || res.ready;
  assign b_move   = bv && (!b_out || out_free);
  assign b_free   = !bv || b_move;
  assign a_adv    = head_valid && b_free;
  assign pop      = a_adv && item_last;
  assign o_load   = bv && b_out && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      xi <= '0;
      yi <= '0;
    end else if (a_adv) begin
      if (x_step_last) begin
        yi <= '0;
        xi <= item_last ? 2'd0 : xi + 1'b1;
      end else begin
        yi <= yi + 1'b1;
      end
    end
  end

  // row banks: bank k holds the rows whose index is k mod 4; read before write
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [PIX_W-1:0] bank [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (a_adv) rd[b] <= bank[cur_x];
      if (a_adv && x_step_last && (head_r[1:0] == 2'(b))) bank[cur_x] <= hv_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else if (a_adv) begin
      bv <= 1'b1;
    end else if (b_move) begin
      bv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_hv   <= hv_sel;
      b_x    <= cur_x;
      b_y    <= cur_y;
      b_span <= span;
      b_rsel <= head_r[1:0];
      b_out  <= head_flags.has_out;
      b_last <= item_last;
      b_done <= head_flags.has_out && head_flags.last_row && head_flags.col_end
                && (xi == 2'd2) && (yi == 2'd2);
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [1:0]       sel;
    vmean = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = SUM_W'(b_hv[PIX_W-1-CH_W*ch -: CH_W]);
      for (int k = 1; k <= 4; k++) begin
        sel = b_rsel - 2'(k);
        if (3'(k) <= b_span) sum = sum + SUM_W'(rd[sel][PIX_W-1-CH_W*ch -: CH_W]);
      end
      vmean[PIX_W-1-CH_W*ch -: CH_W] = floor_mean(sum, b_span + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (o_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      res.red_out     <= vmean[23:16];
      res.green_out   <= vmean[15:8];
      res.blue_out    <= vmean[7:0];
      res.out_column  <= COL_OUT_W'(b_x);
      res.out_row     <= ROW_OUT_W'(b_y);
      res.last_of_run <= b_last;
      res.frame_done  <= b_done;
    end
  end

`ifndef SYNTH
  a_single_column: assert property (@(posedge clk) disable iff (rst)
    head_valid && !head_flags.col_end |-> xi == 2'd0)
    else $error("column step beyond first on a job that is not at row end");

  a_extra_rows: assert property (@(posedge clk) disable iff (rst)
    head_valid && (yi != 2'd0) |-> head_flags.last_row && head_flags.has_out)
    else $error("extra output rows outside the frame's last row");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_done |-> res.last_of_run)
    else $error("frame end not flagged as last of run");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    bv && b_out && !out_free |=> bv && $stable(b_x) && $stable(b_y))
    else $error("read stage lost a result while output was blocked");
`endif

endmodule

// File: rtl/core/rgb_box_blur_5x5_core.sv
// Separable 5x5 box blur on an RGB pixel stream in raster order. Each pixel is
// averaged over the in-row neighbors within two columns, truncated to 8 bits, then
// averaged over the in-frame rows within two rows; divisions floor by the neighbor
// count (3, 4 or 5). A front stage takes one pixel per clock while the queue has
// room and computes the horizontal means; a 4-entry queue hands them to a back
// stage that reads four row banks (MAX_WIDTH x 24 bits each) and, while the output
// is ready, emits one result per clock with its column and row. Then the sustained
// rate is one pixel per clock outside the last row; at the right edge a pixel
// yields three results (nine on the last row), so the input stalls once the queue
// fills. With the queue empty a result passes the queue, read stage and output
// register after its pixel is accepted. Writing either register restarts the frame
// position at column 0, row 0. Widths or heights below 3 act as 3.
module rgb_box_blur_5x5_core #(
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0] cfg_data,
  rbb_pix_if.sink                   pix_in,
  rbb_res_if.source                 res_out
);
  import rbb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int QW = 3 * PIX_W + FLAGS_W + XW + YW;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [XW-1:0]    w_last;
  logic [YW-1:0]    h_last;

  logic                  push;
  logic [2:0][PIX_W-1:0] push_hv;
  job_flags_t            push_flags;
  logic [XW-1:0]         push_x0;
  logic [YW-1:0]         push_r;
  logic                  queue_full;

  logic                  pop;
  logic                  head_valid;
  logic [QW-1:0]         head_data;
  logic [2:0][PIX_W-1:0] head_hv;
  job_flags_t            head_flags;
  logic [XW-1:0]         head_x0;
  logic [YW-1:0]         head_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // clamp the frame size to 3..MAX
  always_comb begin
    if (frame_width < CFG_W'(3)) w_last = XW'(2);
    else if (32'(frame_width) > MAX_WIDTH) w_last = XW'(MAX_WIDTH - 1);
    else w_last = XW'(frame_width - 1'b1);
    if (frame_height < CFG_W'(3)) h_last = YW'(2);
    else if (32'(frame_height) > MAX_HEIGHT) h_last = YW'(MAX_HEIGHT - 1);
    else h_last = YW'(frame_height - 1'b1);
  end

  rbb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix_in),
    .cfg_we     (cfg_we),
    .w_last     (w_last),
    .h_last     (h_last),
    .queue_full (queue_full),
    .push       (push),
    .push_hv    (push_hv),
    .push_flags (push_flags),
    .push_x0    (push_x0),
    .push_r     (push_r)
  );

  rbb_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_hv, push_flags, push_x0, push_r}),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {head_hv, head_flags, head_x0, head_r} = head_data;

  rbb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_hv    (head_hv),
    .head_flags (head_flags),
    .head_x0    (head_x0),
    .head_r     (head_r),
    .pop        (pop),
    .res        (res_out)
  );

endmodule
